// File: src/lsar_pkg.sv
// Package for the light sensor auto-ranging unit.
// Holds action codes, register indexes, reset values, state and config types.
// No dependencies.
`default_nettype none

package lsar_pkg;

	// Result action codes.
	typedef enum logic [1:0] {
		ACT_SAMPLE   = 2'd0,
		ACT_RECONFIG = 2'd1,
		ACT_PUBLISH  = 2'd2,
		ACT_IGNORED  = 2'd3
	} action_t;

	// Request types of an input beat.
	typedef enum logic {
		REQ_START  = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_t;

	// Configuration register indexes.
	localparam int unsigned CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] CFG_AUTO_MODE  = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_START_GAIN = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_START_TIME = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_LOW_THR    = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_HIGH_THR   = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_ADJ_LIMIT  = 3'd5;

	localparam int unsigned CfgDataW = 20;
	localparam int unsigned CountW   = 20;
	localparam int unsigned RawW     = 16;
	localparam int unsigned LuxW     = 24;
	localparam int unsigned AdjW     = 5;

	// Reset values of the registers.
	localparam logic [CountW-1:0] LOW_THR_RESET  = 20'd1000;
	localparam logic [CountW-1:0] HIGH_THR_RESET = 20'd30000;
	localparam logic [AdjW-1:0]   ADJ_LIMIT_RESET = 5'd15;

	// Range ends of the gain and time indexes.
	localparam logic [1:0]      GAIN_TOP      = 2'd3;
	localparam logic [2:0]      TIME_SHORTEST = 3'd7;
	localparam logic [AdjW-1:0] ADJ_MAX       = 5'd31;

	// Gain factors 100x and 200x reduce to a divide by 25 after a shift.
	// floor(x / 25) = (x * DIV25_MUL) >> DIV25_SHIFT, exact for x below 2**22.
	localparam int unsigned DivInW     = 22;
	localparam int unsigned Div25MulW  = 25;
	localparam int unsigned DIV25_SHIFT = 29;
	localparam logic [Div25MulW-1:0] DIV25_MUL = 25'd21474837;

	typedef struct packed {
		logic              auto_mode;
		logic [1:0]        start_gain;
		logic [2:0]        start_time;
		logic [CountW-1:0] low_thr;
		logic [CountW-1:0] high_thr;
		logic [AdjW-1:0]   adj_limit;
	} cfg_t;

	typedef struct packed {
		logic            active;
		logic [1:0]      gain;
		logic [2:0]      time_idx;
		logic [AdjW-1:0] adj_done;
	} range_state_t;

endpackage

`default_nettype wire

// File: src/lsar_if.sv
// Channel interfaces of the light sensor auto-ranging unit: valid/ready plus payload.
// Depends on lsar_pkg for field widths.
`default_nettype none

interface lsar_in_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [lsar_pkg::CountW-1:0]   ch1_count;
	logic [lsar_pkg::RawW-1:0]     raw_lux;

	modport source (output valid, req_type, ch1_count, raw_lux, input ready);
	modport sink (input valid, req_type, ch1_count, raw_lux, output ready);
endinterface

interface lsar_out_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    action;
	logic [1:0]                    gain_index;
	logic [2:0]                    time_index;
	logic [lsar_pkg::LuxW-1:0]     lux_scaled;
	logic [lsar_pkg::AdjW-1:0]     adjust_count;

	modport source (output valid, action, gain_index, time_index, lux_scaled, adjust_count,
		input ready);
	modport sink (input valid, action, gain_index, time_index, lux_scaled, adjust_count,
		output ready);
endinterface

`default_nettype wire

// File: src/lsar_scale.sv
// Lux scaling: raw_lux * 256 divided by the gain factor {1,2,100,200}, truncated.
// Depends on lsar_pkg for widths and the divide-by-25 reciprocal.
`default_nettype none

module lsar_scale (
	input  wire logic [1:0]                gain,
	input  wire logic [lsar_pkg::RawW-1:0] raw_lux,
	output logic [lsar_pkg::LuxW-1:0]      lux_scaled
);

	localparam int unsigned ProdW = lsar_pkg::DivInW + lsar_pkg::Div25MulW;

	logic [lsar_pkg::DivInW-1:0] div_in;
	logic [ProdW-1:0]            prod;
	logic [lsar_pkg::LuxW-1:0]   lux_div25;

	// 256/100 = 64/25 and 256/200 = 32/25, so shift first and divide by 25.
	assign div_in = (gain == 2'd2) ? {raw_lux, 6'd0} : {1'b0, raw_lux, 5'd0};
	assign prod   = ProdW'(div_in) * ProdW'(lsar_pkg::DIV25_MUL);
	assign lux_div25 = lsar_pkg::LuxW'(prod[ProdW-1:lsar_pkg::DIV25_SHIFT]);

	// Gains 1x and 2x are plain shifts.
	always_comb begin
		unique case (gain)
			2'd0:    lux_scaled = {raw_lux, 8'd0};
			2'd1:    lux_scaled = {1'b0, raw_lux, 7'd0};
			default: lux_scaled = lux_div25;
		endcase
	end

endmodule

`default_nettype wire

// File: src/lsar_step.sv
// Ranging decision for one request: next gain, time, count and cycle state, and the action.
// Depends on lsar_pkg for types and codes.
`default_nettype none

module lsar_step (
	input  wire lsar_pkg::cfg_t            cfg,
	input  wire lsar_pkg::range_state_t    cur,
	input  wire logic                      req_type,
	input  wire logic [lsar_pkg::CountW-1:0] ch1_count,
	output lsar_pkg::range_state_t         nxt,
	output lsar_pkg::action_t              action,
	output logic                           use_lux
);

	logic            may_adjust;
	logic            is_low;
	logic            is_high;
	logic            stepped;
	logic [1:0]      gain_adj;
	logic [2:0]      time_adj;
	logic [lsar_pkg::AdjW-1:0] count_inc;

	// A step is tried in auto mode while the limit is not passed; each try counts.
	assign may_adjust = cfg.auto_mode && (cur.adj_done <= cfg.adj_limit);
	assign count_inc  = (cur.adj_done < lsar_pkg::ADJ_MAX) ? cur.adj_done + 1'b1 : cur.adj_done;
	assign is_low     = ch1_count <= cfg.low_thr;
	assign is_high    = !is_low && (ch1_count >= cfg.high_thr);

	// Sensitivity step: gain first, then integration time.
	always_comb begin
		gain_adj = cur.gain;
		time_adj = cur.time_idx;
		stepped  = 1'b0;
		if (is_low) begin
			if (cur.gain < lsar_pkg::GAIN_TOP) begin
				gain_adj = cur.gain + 1'b1;
				stepped  = 1'b1;
			end else if (cur.time_idx != 3'd0) begin
				time_adj = cur.time_idx - 1'b1;
				stepped  = 1'b1;
			end
		end else if (is_high) begin
			if (cur.gain != 2'd0) begin
				gain_adj = cur.gain - 1'b1;
				stepped  = 1'b1;
			end else if (cur.time_idx < lsar_pkg::TIME_SHORTEST) begin
				time_adj = cur.time_idx + 1'b1;
				stepped  = 1'b1;
			end
		end
	end

	// Request handling and state update.
	always_comb begin
		nxt     = cur;
		action  = lsar_pkg::ACT_IGNORED;
		use_lux = 1'b0;
		if (req_type == lsar_pkg::REQ_START) begin
			if (!cur.active) begin
				nxt.active   = 1'b1;
				nxt.gain     = cfg.start_gain;
				nxt.time_idx = cfg.start_time;
				nxt.adj_done = '0;
				action = cfg.auto_mode ? lsar_pkg::ACT_RECONFIG : lsar_pkg::ACT_SAMPLE;
			end
		end else if (cur.active) begin
			use_lux = 1'b1;
			if (may_adjust) begin
				nxt.adj_done = count_inc;
				nxt.gain     = gain_adj;
				nxt.time_idx = time_adj;
			end
			if (may_adjust && stepped) begin
				action = lsar_pkg::ACT_RECONFIG;
			end else begin
				nxt.active = 1'b0;
				action = lsar_pkg::ACT_PUBLISH;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/light_sensor_auto_ranging_unit.sv
// Top level of the light sensor auto-ranging unit.
// Depends on lsar_pkg, lsar_in_if, lsar_out_if, lsar_step and lsar_scale.
//
// Usage:
// - in_ch carries requests: req_type 0 starts a measurement cycle, 1 delivers a
//   sample (ch1_count, raw_lux). out_ch carries one result beat per request:
//   action, the gain and time indexes to program, lux_scaled and adjust_count.
// - Configuration is written through cfg_we/cfg_index/cfg_wdata while no request
//   is in flight; indexes 0..5 are auto mode, start gain, start time, low and
//   high threshold, adjust limit. Other indexes are dropped.
// - An input beat moves from the input register into the result register when
//   that is free or drained, and the result beat is taken from there.
// - Throughput is one beat per cycle while the receiver does not stall. The
//   ranging state is updated in the same cycle a request moves into the result
//   register, so the next request sees it.
// - When the receiver stalls, the result register holds and the input register
//   still takes one more beat; after that in_ch.ready drops until the result
//   is taken.
// - Reset clears both valid flags, the ranging state (idle, gain 0, time 0,
//   count 0) and loads the register reset values.
`default_nettype none

module light_sensor_auto_ranging_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	lsar_in_if.sink                            in_ch,
	lsar_out_if.source                         out_ch,
	input  wire logic                          cfg_we,
	input  wire logic [lsar_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [lsar_pkg::CfgDataW-1:0] cfg_wdata
);

	lsar_pkg::cfg_t         cfg_q;
	lsar_pkg::range_state_t state_q;
	lsar_pkg::range_state_t state_nxt;
	lsar_pkg::action_t      action_nxt;
	logic                   use_lux;
	logic [lsar_pkg::LuxW-1:0] lux_nxt;

	logic                          valid_s1;
	logic                          req_type_s1;
	logic [lsar_pkg::CountW-1:0]   ch1_count_s1;
	logic [lsar_pkg::RawW-1:0]     raw_lux_s1;

	logic                          out_valid_q;
	lsar_pkg::action_t             action_q;
	logic [1:0]                    gain_q;
	logic [2:0]                    time_q;
	logic [lsar_pkg::LuxW-1:0]     lux_q;
	logic [lsar_pkg::AdjW-1:0]     adj_q;

	logic advance;
	logic take_in;

	// Handshake: stage 1 moves on whenever the result register is free or drained.
	assign advance  = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign take_in  = in_ch.valid && in_ch.ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_mode  <= 1'b0;
			cfg_q.start_gain <= 2'd0;
			cfg_q.start_time <= 3'd0;
			cfg_q.low_thr    <= lsar_pkg::LOW_THR_RESET;
			cfg_q.high_thr   <= lsar_pkg::HIGH_THR_RESET;
			cfg_q.adj_limit  <= lsar_pkg::ADJ_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lsar_pkg::CFG_AUTO_MODE:  cfg_q.auto_mode  <= cfg_wdata[0];
				lsar_pkg::CFG_START_GAIN: cfg_q.start_gain <= cfg_wdata[1:0];
				lsar_pkg::CFG_START_TIME: cfg_q.start_time <= cfg_wdata[2:0];
				lsar_pkg::CFG_LOW_THR:    cfg_q.low_thr    <= cfg_wdata;
				lsar_pkg::CFG_HIGH_THR:   cfg_q.high_thr   <= cfg_wdata;
				lsar_pkg::CFG_ADJ_LIMIT:  cfg_q.adj_limit  <= cfg_wdata[lsar_pkg::AdjW-1:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			req_type_s1  <= in_ch.req_type;
			ch1_count_s1 <= in_ch.ch1_count;
			raw_lux_s1   <= in_ch.raw_lux;
		end
	end

	// Decision logic and lux scaling, using the gain in force for this sample.
	lsar_step u_step (
		.cfg       (cfg_q),
		.cur       (state_q),
		.req_type  (req_type_s1),
		.ch1_count (ch1_count_s1),
		.nxt       (state_nxt),
		.action    (action_nxt),
		.use_lux   (use_lux)
	);

	lsar_scale u_scale (
		.gain       (state_q.gain),
		.raw_lux    (raw_lux_s1),
		.lux_scaled (lux_nxt)
	);

	// Ranging state, updated as a request moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q <= action_nxt;
			gain_q   <= state_nxt.gain;
			time_q   <= state_nxt.time_idx;
			lux_q    <= use_lux ? lux_nxt : '0;
			adj_q    <= state_nxt.adj_done;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.action       = action_q;
	assign out_ch.gain_index   = gain_q;
	assign out_ch.time_index   = time_q;
	assign out_ch.lux_scaled   = lux_q;
	assign out_ch.adjust_count = adj_q;

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// Testbench for light_sensor_auto_ranging_unit: directed and random requests, checked beat by beat.
// Depends on lsar_pkg, the channel interfaces in lsar_if.sv and the unit's RTL.

module tb;
	import lsar_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 3;
	localparam int TARGET_ITEMS = 400;
	localparam int PHASE_ITEMS  = 50;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 4;
	localparam int QUIET_LIMIT  = 1000;
	localparam int PRINT_LIMIT  = 100;
	localparam logic [CountW-1:0] COUNT_MAX = '1;
	localparam logic [RawW-1:0]   RAW_MAX   = '1;

	// Ways of choosing a channel-1 count relative to the thresholds.
	localparam int PICK_ANY  = 0;
	localparam int PICK_LOW  = 1;
	localparam int PICK_HIGH = 2;

	typedef struct packed {
		action_t         action;
		logic [1:0]      gain;
		logic [2:0]      time_idx;
		logic [LuxW-1:0] lux;
		logic [AdjW-1:0] adjust;
	} result_t;

	// Tracks the ranging state and settings, and holds the results still due.
	class range_tracker;
		cfg_t         cfg;
		range_state_t ranging;
		result_t      due_results[$];
		int           mismatches;
		int           noted_requests;

		function new();
			cfg = '0;
			cfg.low_thr = LOW_THR_RESET;
			cfg.high_thr = HIGH_THR_RESET;
			cfg.adj_limit = ADJ_LIMIT_RESET;
			ranging = '0;
			mismatches = 0;
			noted_requests = 0;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
			case (idx)
			CFG_AUTO_MODE: cfg.auto_mode = data[0];
			CFG_START_GAIN: cfg.start_gain = data[1:0];
			CFG_START_TIME: cfg.start_time = data[2:0];
			CFG_LOW_THR: cfg.low_thr = data[CountW-1:0];
			CFG_HIGH_THR: cfg.high_thr = data[CountW-1:0];
			CFG_ADJ_LIMIT: cfg.adj_limit = data[AdjW-1:0];
			default: ;
			endcase
		endfunction

		// Works out the result of one accepted request and advances the ranging state.
		function void note_request(req_t req, logic [CountW-1:0] ch1, logic [RawW-1:0] raw);
			result_t     r;
			logic [7:0]  divisor;
			logic        stepped;
			r.lux = '0;
			if (req == REQ_START) begin
				if (ranging.active) begin
					r.action = ACT_IGNORED;
				end else begin
					ranging.active = 1'b1;
					ranging.gain = cfg.start_gain;
					ranging.time_idx = cfg.start_time;
					ranging.adj_done = '0;
					r.action = cfg.auto_mode ? ACT_RECONFIG : ACT_SAMPLE;
				end
			end else if (!ranging.active) begin
				r.action = ACT_IGNORED;
			end else begin
				// The lux is scaled by the gain the sample was taken at.
				case (ranging.gain)
				2'd0: divisor = 8'd1;
				2'd1: divisor = 8'd2;
				2'd2: divisor = 8'd100;
				default: divisor = 8'd200;
				endcase
				r.lux = {raw, 8'd0} / divisor;

				// Every auto decision within the limit counts, even one that publishes.
				stepped = 1'b0;
				if (cfg.auto_mode && ranging.adj_done <= cfg.adj_limit) begin
					if (ranging.adj_done != ADJ_MAX)
						ranging.adj_done = ranging.adj_done + 1'b1;
					if (ch1 <= cfg.low_thr) begin
						if (ranging.gain != GAIN_TOP) begin
							ranging.gain = ranging.gain + 1'b1;
							stepped = 1'b1;
						end else if (ranging.time_idx != 3'd0) begin
							ranging.time_idx = ranging.time_idx - 1'b1;
							stepped = 1'b1;
						end
					end else if (ch1 >= cfg.high_thr) begin
						if (ranging.gain != 2'd0) begin
							ranging.gain = ranging.gain - 1'b1;
							stepped = 1'b1;
						end else if (ranging.time_idx != TIME_SHORTEST) begin
							ranging.time_idx = ranging.time_idx + 1'b1;
							stepped = 1'b1;
						end
					end
				end

				if (stepped) begin
					r.action = ACT_RECONFIG;
				end else begin
					ranging.active = 1'b0;
					r.action = ACT_PUBLISH;
				end
			end
			r.gain = ranging.gain;
			r.time_idx = ranging.time_idx;
			r.adjust = ranging.adj_done;
			noted_requests++;
			due_results.push_back(r);
		endfunction

		task report(string what, int unsigned got, int unsigned want);
			mismatches++;
			if (mismatches <= PRINT_LIMIT)
				$display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
		endtask

		// Compares one result beat with the oldest result still due.
		task check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				report("result beat with nothing due, action", 32'(got.action), 0);
				return;
			end
			want = due_results.pop_front();
			if (got.action != want.action)
				report("action", 32'(got.action), 32'(want.action));
			if (got.gain != want.gain)
				report("gain_index", 32'(got.gain), 32'(want.gain));
			if (got.time_idx != want.time_idx)
				report("time_index", 32'(got.time_idx), 32'(want.time_idx));
			if (got.lux != want.lux)
				report("lux_scaled", 32'(got.lux), 32'(want.lux));
			if (got.adjust != want.adjust)
				report("adjust_count", 32'(got.adjust), 32'(want.adjust));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_wdata;
	bit no_idle = 1'b0;
	bit hold_off = 1'b0;
	range_tracker model = new();

	lsar_in_if in_ch();
	lsar_out_if out_ch();

	light_sensor_auto_ranging_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int idle_len();
		int unsigned roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Channel-1 count placed below, on or above the current thresholds.
	function automatic logic [CountW-1:0] pick_count(int mode);
		int unsigned pick;
		if (mode == PICK_LOW)
			pick = 0;
		else if (mode == PICK_HIGH)
			pick = 4;
		else
			pick = $urandom_range(0, 9);
		case (pick)
		0, 1, 2, 3: return CountW'($urandom_range(0, model.cfg.low_thr));
		4, 5, 6: return CountW'($urandom_range(model.cfg.high_thr, COUNT_MAX));
		7: return ($urandom_range(0, 1) != 0) ? model.cfg.low_thr : model.cfg.high_thr;
		8: return CountW'($urandom_range(model.cfg.low_thr, model.cfg.high_thr));
		default: return CountW'($urandom);
		endcase
	endfunction

	// A setting at an end of its range or anywhere in between.
	function automatic int unsigned pick_level(int unsigned top);
		case ($urandom_range(0, 3))
		0: return 0;
		1: return top;
		default: return $urandom_range(0, top);
		endcase
	endfunction

	// Offers one request beat, waits for it to be taken, then idles a while.
	task automatic offer(req_t req, logic [CountW-1:0] ch1, logic [RawW-1:0] raw);
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.req_type <= req;
		in_ch.ch1_count <= ch1;
		in_ch.raw_lux <= raw;
		do @(posedge clk); while (!in_ch.ready);
		gap = idle_len();
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every due result has come back.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (model.due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		model.write_reg(idx, data);
	endtask

	// Writes every register once the unit has gone idle.
	task automatic set_config(logic mode, logic [1:0] gain, logic [2:0] tidx,
			logic [CountW-1:0] low, logic [CountW-1:0] high, logic [AdjW-1:0] limit);
		wait_idle();
		write_reg(CFG_AUTO_MODE, CfgDataW'(mode));
		write_reg(CFG_START_GAIN, CfgDataW'(gain));
		write_reg(CFG_START_TIME, CfgDataW'(tidx));
		write_reg(CFG_LOW_THR, low);
		write_reg(CFG_HIGH_THR, high);
		write_reg(CFG_ADJ_LIMIT, CfgDataW'(limit));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Notes accepted request beats and checks accepted result beats.
	always @(posedge clk) begin : channel_monitor
		result_t got;
		if (arst_n && in_ch.valid && in_ch.ready)
			model.note_request(req_t'(in_ch.req_type), in_ch.ch1_count, in_ch.raw_lux);
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.action = action_t'(out_ch.action);
			got.gain = out_ch.gain_index;
			got.time_idx = out_ch.time_index;
			got.lux = out_ch.lux_scaled;
			got.adjust = out_ch.adjust_count;
			model.check_result(got);
		end
	end

	// Result side: random stalls, plus one long hold-off when asked for.
	initial begin : receiver
		int stall;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				stall = HOLD_CYCLES;
				hold_off = 1'b0;
			end else begin
				stall = idle_len();
			end
			out_ch.ready <= (stall == 0);
			if (stall != 0) begin
				repeat (stall) @(posedge clk);
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Ends the run when nothing moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout after %0d quiet cycles", QUIET_LIMIT);
		$display("tb: errors");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int base;
		int goal;
		int samples;
		bit long_run;
		logic [CountW-1:0] low_thr;
		logic [CountW-1:0] high_thr;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.req_type = REQ_START;
		in_ch.ch1_count = '0;
		in_ch.raw_lux = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Manual mode at reset settings: a sample while idle and a second start are ignored.
		offer(REQ_SAMPLE, COUNT_MAX, RAW_MAX);
		offer(REQ_START, '0, '0);
		offer(REQ_START, COUNT_MAX, RAW_MAX);
		offer(REQ_SAMPLE, COUNT_MAX, RAW_MAX);
		offer(REQ_SAMPLE, '0, '0);

		// Low light from 1x gain steps through every gain, then the range end publishes.
		set_config(1'b1, 2'd0, 3'd0, LOW_THR_RESET, HIGH_THR_RESET, ADJ_LIMIT_RESET);
		offer(REQ_START, '0, '0);
		repeat (4) offer(REQ_SAMPLE, '0, RAW_MAX);
		// Counts equal to a threshold step; a count in between publishes.
		offer(REQ_START, '0, '0);
		offer(REQ_SAMPLE, LOW_THR_RESET, 16'd12345);
		offer(REQ_SAMPLE, HIGH_THR_RESET, 16'd1);
		offer(REQ_SAMPLE, 20'd5000, 16'd777);

		// Both thresholds met favors the low rule; past the limit the sample publishes.
		set_config(1'b1, 2'd0, 3'd6, 20'd500, 20'd500, 5'd2);
		offer(REQ_START, '0, '0);
		offer(REQ_SAMPLE, 20'd500, 16'd400);
		repeat (3) offer(REQ_SAMPLE, COUNT_MAX, 16'd400);
		// High light at 1x gain steps to the shortest time, then cannot step further.
		offer(REQ_START, '0, '0);
		repeat (2) offer(REQ_SAMPLE, COUNT_MAX, RAW_MAX);

		// A limit of zero allows a single step.
		set_config(1'b1, 2'd2, 3'd3, COUNT_MAX, COUNT_MAX, 5'd0);
		offer(REQ_START, '0, '0);
		repeat (2) offer(REQ_SAMPLE, '0, RAW_MAX);

		// Random phases, each with its own settings, until enough requests have gone in.
		wait_idle();
		base = model.noted_requests;
		phase = 0;
		while (model.noted_requests < base + TARGET_ITEMS) begin
			case (phase)
			0: set_config(1'b1, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
				LOW_THR_RESET, HIGH_THR_RESET, ADJ_MAX);
			1: set_config(1'b0, 2'(pick_level(3)), 3'(pick_level(7)),
				CountW'(pick_level(COUNT_MAX)), CountW'(pick_level(COUNT_MAX)),
				AdjW'(pick_level(ADJ_MAX)));
			default: begin
				if ($urandom_range(0, 1) != 0) begin
					low_thr = CountW'($urandom_range(0, 4000));
					high_thr = CountW'($urandom_range(low_thr, 60000));
				end else begin
					low_thr = CountW'(pick_level(COUNT_MAX));
					high_thr = CountW'(pick_level(COUNT_MAX));
				end
				set_config($urandom_range(0, 3) != 0, 2'(pick_level(3)), 3'(pick_level(7)),
					low_thr, high_thr, AdjW'(pick_level(ADJ_MAX)));
			end
			endcase

			// Every third phase runs back to back; the first also holds off the results.
			no_idle = (phase % 3 == 0);
			if (phase == 0)
				hold_off = 1'b1;

			goal = model.noted_requests + PHASE_ITEMS;
			while (model.noted_requests < goal) begin
				if ($urandom_range(0, 7) == 0) begin
					offer(req_t'($urandom_range(0, 1)), CountW'($urandom), RawW'($urandom));
				end else begin
					// A cycle: a start, then samples around the thresholds.
					offer(REQ_START, CountW'($urandom), RawW'($urandom));
					long_run = ($urandom_range(0, 9) == 0);
					samples = long_run ? $urandom_range(20, 40) : $urandom_range(1, 8);
					for (int i = 0; i < samples; i++)
						offer(REQ_SAMPLE,
							long_run ? pick_count((i % 2 != 0) ? PICK_HIGH : PICK_LOW)
								: pick_count(PICK_ANY),
							RawW'($urandom));
				end
			end
			no_idle = 1'b0;
			phase++;
		end

		wait_idle();
		if (model.mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
